// ===== sv/rssi_proximity_tracker_assert.svh =====
// assertion macros for the tracker modules, used by rpt_ctrl
`ifndef RSSI_PROXIMITY_TRACKER_ASSERT_SVH
`define RSSI_PROXIMITY_TRACKER_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define RPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define RPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rpt_pkg.sv =====
`timescale 1ns / 1ps

package rpt_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_OFFSET   = 2'd0;
  localparam logic [1:0] REG_ADV_MS   = 2'd1;
  localparam logic [1:0] REG_SCAN_MS  = 2'd2;

  localparam logic [6:0]  OFFSET_RESET  = 7'd50;
  localparam logic [15:0] ADV_MS_RESET  = 16'd500;
  localparam logic [15:0] SCAN_MS_RESET = 16'd1500;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_MATCH = 2'd1;

  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_STOP_SCAN = 2'd1;
  localparam logic [1:0] ACT_ADVERTISE = 2'd2;
  localparam logic [1:0] ACT_SCAN      = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_ENTER   = 2'd1;
  localparam logic [1:0] EV_RESTORE = 2'd2;

  localparam logic signed [15:0] AVG_RESET = -16'sd20480;
  localparam logic signed [15:0] DECAY_Q   = -16'sd25600;

  localparam int NUM_W = 15;
  localparam int DEN_W = 7;

  typedef struct packed {
    logic [6:0]  offset;
    logic [15:0] adv_ms;
    logic [15:0] scan_ms;
  } rpt_cfg_t;

  typedef struct packed {
    logic load_in;
    logic do_time;
    logic do_filt;
    logic do_upd;
    logic div_start;
    logic load_out;
  } rpt_cmd_t;

  typedef struct packed {
    logic div_done;
  } rpt_stat_t;

endpackage

// ===== sv/rpt_poll_if.sv =====
`timescale 1ns / 1ps

interface rpt_poll_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [7:0] rssi_dbm;
  logic              connected;
  logic [15:0]       elapsed_ms;

  modport source (output valid, mode, rssi_dbm, connected, elapsed_ms, input ready);
  modport sink (input valid, mode, rssi_dbm, connected, elapsed_ms, output ready);
endinterface

// ===== sv/rpt_result_if.sv =====
`timescale 1ns / 1ps

interface rpt_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         radio_action;
  logic               scanning;
  logic               proximity;
  logic [1:0]         mode_event;
  logic               keep_awake;
  logic [7:0]         effect_speed;
  logic signed [15:0] filtered_rssi;

  modport source (output valid, radio_action, scanning, proximity, mode_event, keep_awake,
                  effect_speed, filtered_rssi, input ready);
  modport sink (input valid, radio_action, scanning, proximity, mode_event, keep_awake,
                effect_speed, filtered_rssi, output ready);
endinterface

// ===== sv/rpt_cfg.sv =====
`timescale 1ns / 1ps

module rpt_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpt_pkg::DATA_W-1:0]  pwdata,
  output logic [rpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rpt_pkg::rpt_cfg_t           cfg
);

  logic [1:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset  <= rpt_pkg::OFFSET_RESET;
      cfg.adv_ms  <= rpt_pkg::ADV_MS_RESET;
      cfg.scan_ms <= rpt_pkg::SCAN_MS_RESET;
    end else if (wr) begin
      unique case (index)
        rpt_pkg::REG_OFFSET:  cfg.offset  <= pwdata[6:0];
        rpt_pkg::REG_ADV_MS:  cfg.adv_ms  <= pwdata[15:0];
        rpt_pkg::REG_SCAN_MS: cfg.scan_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      rpt_pkg::REG_OFFSET:  prdata = {25'd0, cfg.offset};
      rpt_pkg::REG_ADV_MS:  prdata = {16'd0, cfg.adv_ms};
      rpt_pkg::REG_SCAN_MS: prdata = {16'd0, cfg.scan_ms};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/rpt_div.sv =====
`timescale 1ns / 1ps

module rpt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rpt_pkg::NUM_W-1:0]  num,
  input  logic [rpt_pkg::DEN_W-1:0]  den,
  output logic [rpt_pkg::NUM_W-1:0]  quo,
  output logic                       done
);

  localparam int CNT_W = $clog2(rpt_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(rpt_pkg::NUM_W - 1);

  logic [rpt_pkg::DEN_W-1:0] rem;
  logic [rpt_pkg::DEN_W:0]   trial;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      fits;

  assign trial = {rem, quo[rpt_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign done  = busy && (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? rpt_pkg::DEN_W'(trial - {1'b0, den}) : trial[rpt_pkg::DEN_W-1:0];
      quo <= {quo[rpt_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

// ===== sv/rpt_datapath.sv =====
`timescale 1ns / 1ps

module rpt_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  rpt_pkg::rpt_cfg_t        cfg,
  input  rpt_pkg::rpt_cmd_t        cmd,
  output rpt_pkg::rpt_stat_t       stat,
  input  logic [1:0]               mode,
  input  logic signed [7:0]        rssi_dbm,
  input  logic                     connected,
  input  logic [15:0]              elapsed_ms,
  output logic [1:0]               radio_action,
  output logic                     scanning,
  output logic                     proximity,
  output logic [1:0]               mode_event,
  output logic                     keep_awake,
  output logic [7:0]               effect_speed,
  output logic signed [15:0]       filtered_rssi
);

  logic [1:0]               mode_r;
  logic signed [7:0]        rssi_r;
  logic                     conn_r;
  logic [15:0]              elapsed_r;

  logic                     role;
  logic [15:0]              ms_cnt;
  logic signed [15:0]       avg;
  logic                     near;
  logic [1:0]               action_r;
  logic [1:0]               event_r;
  logic                     awake_r;
  logic signed [24:0]       ema_sum;

  logic [16:0]              ms_sum;
  logic [15:0]              ms_sat;
  logic signed [15:0]       x_q;
  logic signed [24:0]       rnd_sum;
  logic signed [15:0]       rnd;
  logic signed [8:0]        wake_db;
  logic signed [8:0]        sleep_db;
  logic signed [16:0]       wake_q;
  logic signed [16:0]       sleep_q;
  logic signed [16:0]       rnd_x;
  logic                     above_wake;
  logic                     below_sleep;

  logic [16:0]              neg_avg;
  logic signed [9:0]        whole;
  logic signed [9:0]        sleep10;
  logic signed [9:0]        lo_clamp;
  logic signed [9:0]        v;
  logic signed [9:0]        diff;
  logic                     span_empty;
  logic [rpt_pkg::NUM_W-1:0] div_num;
  logic [rpt_pkg::DEN_W-1:0] div_den;
  logic [rpt_pkg::NUM_W-1:0] div_quo;
  logic [7:0]               speed;

  // saturating window counter
  assign ms_sum = {1'b0, ms_cnt} + {1'b0, elapsed_r};
  assign ms_sat = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];

  assign x_q = (mode_r == rpt_pkg::MODE_MATCH) ? $signed({rssi_r, 8'h00}) : rpt_pkg::DECAY_Q;

  // round to nearest, ties up
  assign rnd_sum = ema_sum + 25'sd128;
  assign rnd     = rnd_sum[23:8];

  assign wake_db     = $signed({2'b00, cfg.offset}) - 9'sd115;
  assign sleep_db    = $signed({2'b00, cfg.offset}) - 9'sd121;
  assign wake_q      = {wake_db, 8'h00};
  assign sleep_q     = {sleep_db, 8'h00};
  assign rnd_x       = {rnd[15], rnd};
  assign above_wake  = rnd_x > wake_q;
  assign below_sleep = rnd_x < sleep_q;

  // speed operands: whole dBm toward zero, clamped to sleep..-45
  assign neg_avg    = 17'd0 - {avg[15], avg};
  assign whole      = 10'sd0 - $signed({1'b0, neg_avg[16:8]});
  assign sleep10    = {sleep_db[8], sleep_db};
  assign lo_clamp   = (whole < sleep10) ? sleep10 : whole;
  assign v          = (lo_clamp > -10'sd45) ? -10'sd45 : lo_clamp;
  assign diff       = v - sleep10;
  assign span_empty = cfg.offset >= 7'd76;
  assign div_num    = {8'd0, diff[6:0]} * 15'd225;
  assign div_den    = span_empty ? 7'd1 : 7'(7'd76 - cfg.offset);

  assign speed = !near ? 8'd0 : (span_empty ? 8'd255 : 8'd30 + div_quo[7:0]);

  rpt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (stat.div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      role   <= 1'b0;
      ms_cnt <= '0;
      avg    <= rpt_pkg::AVG_RESET;
      near   <= 1'b0;
    end else begin
      if (cmd.do_time) begin
        ms_cnt <= ms_sat;
        if (conn_r) begin
          role <= 1'b0;
        end else if (role && ms_sat >= cfg.scan_ms) begin
          role   <= 1'b0;
          ms_cnt <= '0;
        end else if (!role && ms_sat >= cfg.adv_ms) begin
          role   <= 1'b1;
          ms_cnt <= '0;
        end
      end
      if (cmd.do_upd && role) begin
        case (mode_r)
          rpt_pkg::MODE_MATCH: begin
            avg <= rnd;
            if (above_wake) begin
              near <= 1'b1;
            end
          end
          rpt_pkg::MODE_NONE: begin
            avg <= rnd;
            if (below_sleep) begin
              near <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r    <= mode;
      rssi_r    <= rssi_dbm;
      conn_r    <= connected;
      elapsed_r <= elapsed_ms;
    end
    if (cmd.do_time) begin
      event_r <= rpt_pkg::EV_NONE;
      awake_r <= conn_r;
      if (conn_r) begin
        action_r <= role ? rpt_pkg::ACT_STOP_SCAN : rpt_pkg::ACT_NONE;
      end else if (role && ms_sat >= cfg.scan_ms) begin
        action_r <= rpt_pkg::ACT_ADVERTISE;
      end else if (!role && ms_sat >= cfg.adv_ms) begin
        action_r <= rpt_pkg::ACT_SCAN;
      end else begin
        action_r <= rpt_pkg::ACT_NONE;
      end
    end
    if (cmd.do_filt) begin
      ema_sum <= $signed({{9{x_q[15]}}, x_q}) * 25'sd38
               + $signed({{9{avg[15]}}, avg}) * 25'sd218;
    end
    if (cmd.do_upd && role) begin
      case (mode_r)
        rpt_pkg::MODE_MATCH: begin
          if (!near && above_wake) begin
            event_r <= rpt_pkg::EV_ENTER;
          end
          if (near || above_wake) begin
            awake_r <= 1'b1;
          end
        end
        rpt_pkg::MODE_NONE: begin
          if (near && below_sleep) begin
            event_r <= rpt_pkg::EV_RESTORE;
          end
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      radio_action  <= action_r;
      scanning      <= role;
      proximity     <= near;
      mode_event    <= event_r;
      keep_awake    <= awake_r;
      effect_speed  <= speed;
      filtered_rssi <= avg;
    end
  end

endmodule

// ===== sv/rpt_ctrl.sv =====
`timescale 1ns / 1ps
`include "rssi_proximity_tracker_assert.svh"

module rpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rpt_pkg::rpt_stat_t stat,
  output rpt_pkg::rpt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_FILT,
    S_UPD,
    S_DIVGO,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load_in   = in_ready && in_valid;
    cmd.do_time   = (state == S_TIME);
    cmd.do_filt   = (state == S_FILT);
    cmd.do_upd    = (state == S_UPD);
    cmd.div_start = (state == S_DIVGO);
    cmd.load_out  = (state == S_FIN) && out_free;
    state_next    = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_TIME;
      S_TIME:  state_next = S_FILT;
      S_FILT:  state_next = S_UPD;
      S_UPD:   state_next = S_DIVGO;
      S_DIVGO: state_next = S_DIV;
      S_DIV:   if (stat.div_done) state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RPT_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || out_ready, "result overwritten")
  `RPT_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded result not shown")
  `RPT_ASSERT_NEXT(a_one_in_flight, cmd.load_in, !in_ready, "second item taken in flight")
  `RPT_ASSERT_NOW(a_div_done_state, stat.div_done, state == S_DIV, "divider done out of step")

endmodule

// ===== sv/rssi_proximity_tracker.sv =====
`timescale 1ns / 1ps

// Proximity tracker: each poll item on the poll channel yields one result item on the
// result channel. From acceptance an item passes through window timing, filter product,
// filter update, divider launch, the bit-serial divider of the speed mapping and the
// load of the output register, which waits while the previous result is unread. The next
// poll is accepted as soon as the result is loaded, while that result still waits in the
// output register. Configuration registers sit on the APB port at byte addresses
// 0 (sensitivity offset), 4 (advertise window ms) and 8 (scan window ms); write them
// only while no item is in flight.
module rssi_proximity_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rpt_pkg::ADDR_W-1:0]  paddr,
  input  logic [rpt_pkg::DATA_W-1:0]  pwdata,
  output logic [rpt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  rpt_poll_if.sink                    poll,
  rpt_result_if.source                result
);

  rpt_pkg::rpt_cfg_t  cfg;
  rpt_pkg::rpt_cmd_t  cmd;
  rpt_pkg::rpt_stat_t stat;

  rpt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poll.valid),
    .in_ready  (poll.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (poll.mode),
    .rssi_dbm      (poll.rssi_dbm),
    .connected     (poll.connected),
    .elapsed_ms    (poll.elapsed_ms),
    .radio_action  (result.radio_action),
    .scanning      (result.scanning),
    .proximity     (result.proximity),
    .mode_event    (result.mode_event),
    .keep_awake    (result.keep_awake),
    .effect_speed  (result.effect_speed),
    .filtered_rssi (result.filtered_rssi)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;

  typedef enum int {SCENE_NEAR, SCENE_AWAY, SCENE_LINK, SCENE_NOISE} scene_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [7:0] rssi;
    logic              conn;
    logic [15:0]       elapsed;
  } poll_t;

  typedef struct packed {
    logic [1:0]         action;
    logic               scanning;
    logic               proximity;
    logic [1:0]         mode_event;
    logic               keep_awake;
    logic [7:0]         speed;
    logic signed [15:0] filtered;
  } reply_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rpt_pkg::ADDR_W-1:0] paddr;
  logic [rpt_pkg::DATA_W-1:0] pwdata;
  logic [rpt_pkg::DATA_W-1:0] prdata;
  logic pready;

  rpt_poll_if poll_ch();
  rpt_result_if result_ch();

  rssi_proximity_tracker uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .poll(poll_ch),
    .result(result_ch)
  );

  // tracker state as predicted
  logic [6:0]  cfg_off;
  logic [15:0] cfg_adv;
  logic [15:0] cfg_scan;
  bit          role_scan;
  int          since_ms;
  int          avg_q;
  bit          near;

  reply_t replies_due[$];
  bit idle_on;
  bit rx_hold_req;
  int n_errors;
  int n_polls;
  int n_checked;
  int n_settings;
  int n_switches;
  int n_enter;
  int n_restore;
  int n_linked;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int smooth(int x, int a);
    return (38 * x + 218 * a + 128) >>> 8;
  endfunction

  function automatic logic [7:0] speed_map(int a, int sleep_db);
    int whole;
    int span;
    int v;
    whole = -((-a) >>> 8);
    span = -45 - sleep_db;
    if (span <= 0) begin
      return 8'd255;
    end
    v = whole;
    if (v < sleep_db) v = sleep_db;
    if (v > -45) v = -45;
    return 8'(30 + ((v - sleep_db) * 225) / span);
  endfunction

  function automatic reply_t track_poll(poll_t p);
    reply_t r;
    int wake_q;
    int sleep_db;
    r = '0;
    wake_q = (int'(cfg_off) - 115) * 256;
    sleep_db = int'(cfg_off) - 121;
    since_ms = since_ms + int'(p.elapsed);
    if (since_ms > 65535) since_ms = 65535;
    if (p.conn) begin
      if (role_scan) begin
        role_scan = 1'b0;
        r.action = rpt_pkg::ACT_STOP_SCAN;
      end
      r.keep_awake = 1'b1;
      n_linked++;
    end else if (role_scan && since_ms >= int'(cfg_scan)) begin
      role_scan = 1'b0;
      r.action = rpt_pkg::ACT_ADVERTISE;
      since_ms = 0;
      n_switches++;
    end else if (!role_scan && since_ms >= int'(cfg_adv)) begin
      role_scan = 1'b1;
      r.action = rpt_pkg::ACT_SCAN;
      since_ms = 0;
      n_switches++;
    end
    if (role_scan) begin
      if (p.mode == rpt_pkg::MODE_MATCH) begin
        avg_q = smooth(int'(p.rssi) * 256, avg_q);
        if (!near && avg_q > wake_q) begin
          near = 1'b1;
          r.mode_event = rpt_pkg::EV_ENTER;
          n_enter++;
        end
        if (near) r.keep_awake = 1'b1;
      end else if (p.mode == rpt_pkg::MODE_NONE) begin
        avg_q = smooth(int'(rpt_pkg::DECAY_Q), avg_q);
        if (near && avg_q < sleep_db * 256) begin
          near = 1'b0;
          r.mode_event = rpt_pkg::EV_RESTORE;
          n_restore++;
        end
      end
    end
    if (near) r.speed = speed_map(avg_q, sleep_db);
    r.scanning = role_scan;
    r.proximity = near;
    r.filtered = avg_q[15:0];
    return r;
  endfunction

  function automatic poll_t mk(logic [1:0] m, logic signed [7:0] r, logic c, logic [15:0] e);
    poll_t p;
    p.mode = m;
    p.rssi = r;
    p.conn = c;
    p.elapsed = e;
    return p;
  endfunction

  function automatic poll_t make_poll(scene_t scene);
    poll_t p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) p.elapsed = 16'($urandom_range(0, 120));
    else if (pick < 95) p.elapsed = 16'($urandom_range(0, 2000));
    else p.elapsed = 16'($urandom_range(0, 65535));
    case (scene)
      SCENE_NEAR: begin
        p.mode = ($urandom_range(0, 99) < 85) ? rpt_pkg::MODE_MATCH
                                               : 2'($urandom_range(0, 3));
        p.rssi = -8'($urandom_range(0, 60));
        p.conn = ($urandom_range(0, 99) < 3);
      end
      SCENE_AWAY: begin
        p.mode = ($urandom_range(0, 99) < 70) ? rpt_pkg::MODE_NONE : rpt_pkg::MODE_MATCH;
        p.rssi = -8'($urandom_range(60, 128));
        p.conn = ($urandom_range(0, 99) < 3);
      end
      SCENE_LINK: begin
        p.mode = 2'($urandom_range(0, 3));
        p.rssi = -8'($urandom_range(0, 128));
        p.conn = ($urandom_range(0, 99) < 80);
      end
      default: begin
        p.mode = 2'($urandom_range(0, 3));
        p.rssi = -8'($urandom_range(0, 128));
        p.conn = 1'($urandom_range(0, 1));
        p.elapsed = 16'($urandom_range(0, 65535));
      end
    endcase
    return p;
  endfunction

  task automatic send_poll(poll_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.mode <= p.mode;
    poll_ch.rssi_dbm <= p.rssi;
    poll_ch.connected <= p.conn;
    poll_ch.elapsed_ms <= p.elapsed;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    replies_due.push_back(track_poll(p));
    n_polls++;
  endtask

  task automatic drain_replies;
    poll_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rpt_pkg::REG_OFFSET: cfg_off = data[6:0];
      rpt_pkg::REG_ADV_MS: cfg_adv = data[15:0];
      rpt_pkg::REG_SCAN_MS: cfg_scan = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_register(logic [1:0] idx, logic [31:0] want);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == rpt_pkg::REG_OFFSET) ? 32'h7F : 32'hFFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (want & mask)) begin
      flag_error($sformatf("register %0d reads %0h, expected %0h", idx, got & mask, want & mask));
    end
    @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] off, logic [15:0] adv, logic [15:0] scan);
    apb_write(rpt_pkg::REG_OFFSET, 32'(off));
    apb_write(rpt_pkg::REG_ADV_MS, 32'(adv));
    apb_write(rpt_pkg::REG_SCAN_MS, 32'(scan));
    check_register(rpt_pkg::REG_OFFSET, 32'(off));
    check_register(rpt_pkg::REG_ADV_MS, 32'(adv));
    check_register(rpt_pkg::REG_SCAN_MS, 32'(scan));
    n_settings++;
  endtask

  task automatic run_traffic(int count);
    scene_t scene;
    int left;
    int pick;
    left = 0;
    scene = SCENE_NEAR;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) idle_on = !idle_on;
      if (left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) scene = SCENE_NEAR;
        else if (pick < 70) scene = SCENE_AWAY;
        else if (pick < 80) scene = SCENE_LINK;
        else scene = SCENE_NOISE;
        left = $urandom_range(8, 30);
      end
      left--;
      send_poll(make_poll(scene));
    end
    drain_replies();
  endtask

  task automatic test_register_defaults;
    check_register(rpt_pkg::REG_OFFSET, 32'(rpt_pkg::OFFSET_RESET));
    check_register(rpt_pkg::REG_ADV_MS, 32'(rpt_pkg::ADV_MS_RESET));
    check_register(rpt_pkg::REG_SCAN_MS, 32'(rpt_pkg::SCAN_MS_RESET));
  endtask

  task automatic test_directed;
    idle_on = 1'b1;
    send_poll(mk(MODE_OTHER, 8'sd0, 1'b0, 16'd0));
    send_poll(mk(rpt_pkg::MODE_MATCH, -8'sd128, 1'b0, 16'd0));
    // window boundary reached exactly
    send_poll(mk(rpt_pkg::MODE_MATCH, 8'sd0, 1'b0, 16'd500));
    repeat (3) send_poll(mk(rpt_pkg::MODE_MATCH, 8'sd0, 1'b0, 16'd10));
    send_poll(mk(MODE_SPARE, -8'sd128, 1'b0, 16'd10));
    send_poll(mk(MODE_OTHER, -8'sd50, 1'b0, 16'd10));
    // central connects while scanning
    send_poll(mk(rpt_pkg::MODE_MATCH, -8'sd128, 1'b1, 16'd0));
    send_poll(mk(rpt_pkg::MODE_NONE, 8'sd0, 1'b1, 16'd65535));
    send_poll(mk(rpt_pkg::MODE_NONE, 8'sd0, 1'b1, 16'd65535));
    send_poll(mk(rpt_pkg::MODE_MATCH, -8'sd30, 1'b0, 16'd0));
    repeat (9) send_poll(mk(rpt_pkg::MODE_NONE, -8'sd128, 1'b0, 16'd1));
    send_poll(mk(rpt_pkg::MODE_MATCH, -8'sd128, 1'b0, 16'd1499));
    send_poll(mk(MODE_OTHER, -8'sd1, 1'b0, 16'd65535));
    send_poll(mk(rpt_pkg::MODE_MATCH, -8'sd1, 1'b0, 16'd0));
    drain_replies();
  endtask

  task automatic test_zero_windows;
    set_config(7'd0, 16'd0, 16'd0);
    run_traffic(30);
  endtask

  task automatic test_backpressure;
    set_config(7'd60, 16'd100, 16'd3000);
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_poll(make_poll(SCENE_NEAR));
    end
    drain_replies();
  endtask

  task automatic test_random_sweep;
    logic [6:0]  offs[7];
    logic [15:0] advs[7];
    logic [15:0] scans[7];
    offs = '{7'd50, 7'd0, 7'd127, 7'd100, 7'd76, 7'd75, 7'($urandom_range(0, 127))};
    advs = '{16'd500, 16'd1, 16'd65535, 16'd300, 16'd200, 16'd50,
             16'($urandom_range(0, 4000))};
    scans = '{16'd1500, 16'd1, 16'd65535, 16'd800, 16'd1000, 16'd2000,
              16'($urandom_range(0, 4000))};
    for (int k = 0; k < 7; k++) begin
      set_config(offs[k], advs[k], scans[k]);
      run_traffic(180);
    end
  endtask

  initial begin : rx_side
    int wait_cycles;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        wait_cycles = HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (wait_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_reply
    reply_t got;
    reply_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.action = result_ch.radio_action;
      got.scanning = result_ch.scanning;
      got.proximity = result_ch.proximity;
      got.mode_event = result_ch.mode_event;
      got.keep_awake = result_ch.keep_awake;
      got.speed = result_ch.effect_speed;
      got.filtered = result_ch.filtered_rssi;
      if (replies_due.size() == 0) begin
        flag_error($sformatf("result with no poll pending: act=%0d rssi_q=%0d",
                             got.action, got.filtered));
      end else begin
        want = replies_due.pop_front();
        n_checked++;
        if (got !== want) begin
          flag_error($sformatf(
            "item %0d want act=%0d scan=%0d prox=%0d ev=%0d awake=%0d speed=%0d q=%0d",
            n_checked, want.action, want.scanning, want.proximity, want.mode_event,
            want.keep_awake, want.speed, want.filtered));
          if (n_errors <= 10) begin
            $display("         got act=%0d scan=%0d prox=%0d ev=%0d awake=%0d speed=%0d q=%0d",
                     got.action, got.scanning, got.proximity, got.mode_event,
                     got.keep_awake, got.speed, got.filtered);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no item moved for %0d cycles, %0d results pending", quiet_cycles,
                 replies_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    poll_ch.valid <= 1'b0;
    poll_ch.mode <= rpt_pkg::MODE_NONE;
    poll_ch.rssi_dbm <= '0;
    poll_ch.connected <= 1'b0;
    poll_ch.elapsed_ms <= '0;
    cfg_off = rpt_pkg::OFFSET_RESET;
    cfg_adv = rpt_pkg::ADV_MS_RESET;
    cfg_scan = rpt_pkg::SCAN_MS_RESET;
    role_scan = 1'b0;
    since_ms = 0;
    avg_q = int'(rpt_pkg::AVG_RESET);
    near = 1'b0;
    idle_on = 1'b1;
    rx_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_directed();
    test_zero_windows();
    test_backpressure();
    test_random_sweep();

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", replies_due.size()));
    end
    $display("%0d polls, %0d results checked across %0d register settings",
             n_polls, n_checked, n_settings);
    $display("%0d role switches, %0d proximity entries, %0d releases, %0d connected polls",
             n_switches, n_enter, n_restore, n_linked);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
